FILE: hdl/hrs_pkg.sv
// Shared types and constants for the hourly relay scheduler.
// Used by every module in hdl/; depends on nothing else.
package hrs_pkg;

    // Relay count and configuration port geometry.
    localparam int NUM_RELAYS = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 57;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_PROFILE_A = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PROFILE_B = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PROFILE_C = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PROFILE_D = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OVR_ENABLE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OVR_LEVEL = 3'd5;

    // Profile packing.
    localparam int HOUR_MASK_W = 24;
    localparam int PULSE_BIT = 24;
    localparam int ON_POS = 25;
    localparam int DEF_PULSE_SEC_BITS = 16;

    // System modes.
    localparam logic [1:0] SM_DAYTIME = 2'd0;
    localparam logic [1:0] SM_OUTAGE = 2'd2;

    // Timing constants in milliseconds.
    localparam logic [31:0] LOSS_ON_MS = 32'd60000;
    localparam logic [31:0] LOSS_OFF_MS = 32'd120000;
    localparam int MS_PER_SEC = 1000;
    localparam int MS_PER_SEC_W = 10;

    // Hour handling.
    localparam logic [4:0] FALLBACK_HOUR = 5'd12;
    localparam logic [4:0] LAST_HOUR = 5'd23;

    // The relay that keeps pulsing during power loss.
    localparam int LOSS_RELAY = 2;

    // Input word of the tick channel.
    typedef struct packed {
        logic [31:0] now_ms;
        logic [4:0]  hour_of_day;
        logic [1:0]  system_mode;
    } tick_word_t;

    // Output word of the result channel.
    typedef struct packed {
        logic [NUM_RELAYS-1:0] relay_levels;
        logic [NUM_RELAYS-1:0] changed_mask;
    } result_word_t;

    // Decoded relay profile with durations already in milliseconds.
    typedef struct packed {
        logic [HOUR_MASK_W-1:0] hour_mask;
        logic                   pulse_mode;
        logic [31:0]            on_ms;
        logic [31:0]            off_ms;
    } relay_prof_t;

    // Per-tick control handed from the top level to each relay lane.
    typedef struct packed {
        logic        advance;
        logic        loss_mode;
        logic        loss_entry;
        logic [4:0]  hour;
        logic [31:0] now_ms;
    } lane_ctl_t;

endpackage

FILE: hdl/hrs_cfg.sv
// Configuration register file: relay profiles and manual overrides.
// Pulse durations are converted to milliseconds when written. Uses hrs_pkg.
module hrs_cfg #(
    parameter int PULSE_SEC_BITS = hrs_pkg::DEF_PULSE_SEC_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [hrs_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [hrs_pkg::CFG_DATA_W-1:0]          cfg_data,
    output hrs_pkg::relay_prof_t [hrs_pkg::NUM_RELAYS-1:0] profiles,
    output logic [hrs_pkg::NUM_RELAYS-1:0]          ovr_enable,
    output logic [hrs_pkg::NUM_RELAYS-1:0]          ovr_level
);

    // The profile is widened so that fields beyond the register read as zero.
    localparam int EXT_W = (hrs_pkg::ON_POS + 2 * PULSE_SEC_BITS > hrs_pkg::CFG_DATA_W) ?
                           hrs_pkg::ON_POS + 2 * PULSE_SEC_BITS : hrs_pkg::CFG_DATA_W;
    localparam int MS_W = PULSE_SEC_BITS + hrs_pkg::MS_PER_SEC_W;

    logic [EXT_W-1:0]          data_ext;
    logic [PULSE_SEC_BITS-1:0] on_sec;
    logic [PULSE_SEC_BITS-1:0] off_sec;
    logic [MS_W-1:0]           on_prod;
    logic [MS_W-1:0]           off_prod;
    hrs_pkg::relay_prof_t      prof_next;

    hrs_pkg::relay_prof_t [hrs_pkg::NUM_RELAYS-1:0] profiles_reg;
    logic [hrs_pkg::NUM_RELAYS-1:0] ovr_enable_reg;
    logic [hrs_pkg::NUM_RELAYS-1:0] ovr_level_reg;

    // Decode the written word into a profile.
    always_comb
    begin
        data_ext = EXT_W'(cfg_data);
        on_sec = data_ext[hrs_pkg::ON_POS +: PULSE_SEC_BITS];
        off_sec = data_ext[hrs_pkg::ON_POS + PULSE_SEC_BITS +: PULSE_SEC_BITS];
        on_prod = MS_W'(on_sec) * MS_W'(hrs_pkg::MS_PER_SEC);
        off_prod = MS_W'(off_sec) * MS_W'(hrs_pkg::MS_PER_SEC);
        prof_next.hour_mask = data_ext[hrs_pkg::HOUR_MASK_W-1:0];
        prof_next.pulse_mode = data_ext[hrs_pkg::PULSE_BIT];
        prof_next.on_ms = 32'(on_prod);
        prof_next.off_ms = 32'(off_prod);
    end

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profiles_reg <= '0;
            ovr_enable_reg <= '0;
            ovr_level_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                hrs_pkg::REG_PROFILE_A: profiles_reg[0] <= prof_next;
                hrs_pkg::REG_PROFILE_B: profiles_reg[1] <= prof_next;
                hrs_pkg::REG_PROFILE_C: profiles_reg[2] <= prof_next;
                hrs_pkg::REG_PROFILE_D: profiles_reg[3] <= prof_next;
                hrs_pkg::REG_OVR_ENABLE:
                    ovr_enable_reg <= cfg_data[hrs_pkg::NUM_RELAYS-1:0];
                hrs_pkg::REG_OVR_LEVEL:
                    ovr_level_reg <= cfg_data[hrs_pkg::NUM_RELAYS-1:0];
                default: ;
            endcase
        end
    end

    assign profiles = profiles_reg;
    assign ovr_enable = ovr_enable_reg;
    assign ovr_level = ovr_level_reg;

endmodule

FILE: hdl/hrs_relay_lane.sv
// One relay lane: hour mask lookup, pulse phase timer and its state.
// Uses hrs_pkg types for the profile and the per-tick control.
module hrs_relay_lane #(
    parameter bit LOSS_PULSE = 1'b0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hrs_pkg::lane_ctl_t   ctl,
    input  hrs_pkg::relay_prof_t prof,
    output logic                 level
);

    logic        phase_reg;
    logic        phase_next;
    logic [31:0] start_reg;
    logic [31:0] start_next;
    logic        was_active_reg;

    logic        active;
    logic        run_pulse;
    logic        restart;
    logic        eff_phase;
    logic [31:0] eff_start;
    logic [31:0] elapsed;
    logic [31:0] dur;
    logic [31:0] on_ms;
    logic [31:0] off_ms;
    logic        toggle;

    // Phase evaluation: restart in the on phase, then check for expiry.
    always_comb
    begin
        active = prof.hour_mask[ctl.hour];
        if (ctl.loss_mode)
        begin
            run_pulse = LOSS_PULSE;
            restart = ctl.loss_entry;
            on_ms = hrs_pkg::LOSS_ON_MS;
            off_ms = hrs_pkg::LOSS_OFF_MS;
        end
        else
        begin
            run_pulse = active & prof.pulse_mode;
            restart = ~was_active_reg;
            on_ms = prof.on_ms;
            off_ms = prof.off_ms;
        end
        eff_phase = restart | phase_reg;
        eff_start = restart ? ctl.now_ms : start_reg;
        elapsed = ctl.now_ms - eff_start;
        dur = eff_phase ? on_ms : off_ms;
        toggle = (elapsed >= dur);
        phase_next = eff_phase ^ toggle;
        start_next = toggle ? ctl.now_ms : eff_start;
        if (ctl.loss_mode)
            level = LOSS_PULSE & phase_next;
        else
            level = active & (~prof.pulse_mode | phase_next);
    end

    // Lane state, updated once per tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            start_reg <= '0;
            was_active_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            if (run_pulse)
            begin
                phase_reg <= phase_next;
                start_reg <= start_next;
            end
            if (!ctl.loss_mode)
                was_active_reg <= active;
        end
    end

endmodule

FILE: hdl/hourly_relay_scheduler_with_pulse.sv
// Top level of the hourly relay scheduler with pulse operation.
// Instantiates hrs_cfg and four hrs_relay_lane units; uses hrs_pkg.
//
// Usage:
//   Configuration: cfg_wr_en, cfg_index and cfg_data write one register per
//   cycle (profiles of relays 0 to 3 at indexes 0 to 3, override enable at 4,
//   override level at 5). Write only while no tick is in flight.
//   Tick channel: tick_valid/tick_stall carry now_ms, hour_of_day and
//   system_mode. A word is taken when tick_valid is high and tick_stall low.
//   Result channel: result_valid/result_stall carry relay_levels and
//   changed_mask, one result word per tick word, in order.
//   Datapath: a taken tick is held in the input register, evaluated from it,
//   and its result word is loaded into the result register when it is free.
//   Throughput: one tick per cycle while result_stall is low; all four relays
//   run in parallel, one subtract and compare each between the registers.
//   Stall: while result_stall holds a pending result, one more tick waits in
//   the input register, after which tick_stall rises.
//   Reset: all registers but the tick and result data clear to zero, pulse
//   phases and relay levels too, and the previous mode reads as day mode.
module hourly_relay_scheduler_with_pulse #(
    parameter int PULSE_SEC_BITS = hrs_pkg::DEF_PULSE_SEC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [hrs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hrs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             tick_valid,
    output logic                             tick_stall,
    input  hrs_pkg::tick_word_t              tick,
    output logic                             result_valid,
    input  logic                             result_stall,
    output hrs_pkg::result_word_t            result
);

    hrs_pkg::relay_prof_t [hrs_pkg::NUM_RELAYS-1:0] profiles;
    logic [hrs_pkg::NUM_RELAYS-1:0] ovr_enable;
    logic [hrs_pkg::NUM_RELAYS-1:0] ovr_level;

    hrs_pkg::tick_word_t   tick_reg;
    logic                  tick_valid_reg;
    hrs_pkg::result_word_t result_reg;
    logic                  result_valid_reg;
    logic [1:0]            prev_mode_reg;
    logic [hrs_pkg::NUM_RELAYS-1:0] levels_reg;

    logic                  advance;
    logic                  take_tick;
    logic                  loss_mode;
    hrs_pkg::lane_ctl_t    ctl;
    logic [hrs_pkg::NUM_RELAYS-1:0] lane_level;
    logic [hrs_pkg::NUM_RELAYS-1:0] levels_next;

    // Configuration registers.
    hrs_cfg #(
        .PULSE_SEC_BITS(PULSE_SEC_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .profiles  (profiles),
        .ovr_enable(ovr_enable),
        .ovr_level (ovr_level)
    );

    // Handshake: the held tick moves on when the result register is free.
    assign advance = tick_valid_reg & (~result_valid_reg | ~result_stall);
    assign tick_stall = tick_valid_reg & ~advance;
    assign take_tick = tick_valid & ~tick_stall;

    // Per-tick control shared by the lanes; unsynchronized hours fall back.
    always_comb
    begin
        loss_mode = (tick_reg.system_mode == hrs_pkg::SM_OUTAGE);
        ctl.advance = advance;
        ctl.loss_mode = loss_mode;
        ctl.loss_entry = loss_mode & (prev_mode_reg != hrs_pkg::SM_OUTAGE);
        ctl.hour = (tick_reg.hour_of_day > hrs_pkg::LAST_HOUR) ?
                   hrs_pkg::FALLBACK_HOUR : tick_reg.hour_of_day;
        ctl.now_ms = tick_reg.now_ms;
    end

    // Relay lanes.
    for (genvar i = 0; i < hrs_pkg::NUM_RELAYS; i++)
    begin : g_lane
        hrs_relay_lane #(
            .LOSS_PULSE(i == hrs_pkg::LOSS_RELAY)
        ) u_lane (
            .clk  (clk),
            .rst_n(rst_n),
            .ctl  (ctl),
            .prof (profiles[i]),
            .level(lane_level[i])
        );
    end

    // Manual overrides apply outside power loss only.
    always_comb
    begin
        for (int i = 0; i < hrs_pkg::NUM_RELAYS; i++)
        begin
            if (!loss_mode && ovr_enable[i])
                levels_next[i] = ovr_level[i];
            else
                levels_next[i] = lane_level[i];
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_valid_reg <= 1'b0;
        else if (take_tick)
            tick_valid_reg <= 1'b1;
        else if (advance)
            tick_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take_tick)
            tick_reg <= tick;
    end

    // Result register and block-level state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            prev_mode_reg <= hrs_pkg::SM_DAYTIME;
            levels_reg <= '0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
            prev_mode_reg <= tick_reg.system_mode;
            levels_reg <= levels_next;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.relay_levels <= levels_next;
            result_reg.changed_mask <= levels_next ^ levels_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

endmodule
